>>> hdl/fpsg_pkg.sv
// ----------------------------------------------------------------------------
// fpsg_pkg
// Shared types, widths and the rule table of the fuzzy PD servo gain block.
// ----------------------------------------------------------------------------
package fpsg_pkg;

  localparam int IN_W      = 16;
  localparam int DRIVE_W   = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam int BRK_W     = 7;
  localparam int WGT_W     = 7;
  localparam int SEG_W     = 3;
  localparam int LVL_W     = 3;

  localparam int DIV_NW = 22;
  localparam int DIV_DW = 15;
  localparam int DIV_QW = 11;
  localparam int DIV_WW = DIV_NW + DIV_QW;

  localparam logic [WGT_W-1:0] FULL_WEIGHT = 7'd100;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_BREAK1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_BREAK2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_BREAK3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_BREAK1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_BREAK2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_BREAK3 = 3'd6;

  localparam logic [LVL_W-1:0] RULE_TAB [7][7] = '{
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6},
    '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd6},
    '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6},
    '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6},
    '{3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6}
  };

  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic              frc;
    logic [WGT_W-1:0]  fw;
    logic [DIV_DW-1:0] num;
    logic [DIV_DW-1:0] den;
  } mem_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic             frc;
    logic [WGT_W-1:0] fw;
  } side_t;

  function automatic mem_t member_sel(logic signed [IN_W-1:0] x, logic [BRK_W-1:0] r1,
                                      logic [BRK_W-1:0] r2, logic [BRK_W-1:0] r3);
    logic signed [17:0] xs, b1, b2, b3, n, d;
    mem_t m;
    xs = {{2{x[IN_W-1]}}, x};
    b1 = {3'b000, r1, 8'h00};
    b2 = {3'b000, r2, 8'h00};
    b3 = {3'b000, r3, 8'h00};
    m = '0;
    n = '0;
    d = '0;
    if (xs > -b3 && xs < b3) begin
      priority if (xs <= -b2) begin
        m.seg = 3'd1; n = -b2 - xs; d = b3 - b2;
      end else if (xs <= -b1) begin
        m.seg = 3'd2; n = -b1 - xs; d = b2 - b1;
      end else if (xs <= 18'sd0) begin
        m.seg = 3'd3; n = -xs; d = b1;
      end else if (xs <= b1) begin
        m.seg = 3'd4; n = b1 - xs; d = b1;
      end else if (xs <= b2) begin
        m.seg = 3'd5; n = b2 - xs; d = b2 - b1;
      end else begin
        m.seg = 3'd6; n = b3 - xs; d = b3 - b2;
      end
      if (n <= 18'sd0) begin
        m.frc = 1'b1;
      end else if (n >= d) begin
        m.frc = 1'b1;
        m.fw  = FULL_WEIGHT;
      end else begin
        m.num = n[DIV_DW-1:0];
        m.den = d[DIV_DW-1:0];
      end
    end else if (xs <= -b3) begin
      m.seg = 3'd1; m.frc = 1'b1; m.fw = FULL_WEIGHT;
    end else begin
      m.seg = 3'd6; m.frc = 1'b1;
    end
    return m;
  endfunction

endpackage

>>> hdl/fpsg_if.sv
// ----------------------------------------------------------------------------
// fpsg_in_if / fpsg_out_if
// Request channels of the fuzzy PD servo gain block.
// ----------------------------------------------------------------------------
interface fpsg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] error_value;
  logic signed [15:0] error_rate;
  modport source (output valid, output error_value, output error_rate, input ready);
  modport sink (input valid, input error_value, input error_rate, output ready);
endinterface

interface fpsg_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] drive_value;
  logic        no_rule_fired;
  modport source (output valid, output drive_value, output no_rule_fired, input ready);
  modport sink (input valid, input drive_value, input no_rule_fired, output ready);
endinterface

>>> hdl/fpsg_div.sv
// ----------------------------------------------------------------------------
// fpsg_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpsg_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [fpsg_pkg::DIV_NW-1:0] in_num,
  input  logic [fpsg_pkg::DIV_DW-1:0] in_den,
  output logic                       out_valid,
  output logic [fpsg_pkg::DIV_QW-1:0] out_quo
);
  import fpsg_pkg::*;

  logic [DIV_NW-1:0] rem_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];
  logic              vld_r [DIV_QW];

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    logic [DIV_NW-1:0] rem_in, rem_nxt;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_QW-1:0] quo_in, quo_nxt;
    logic              vld_in;
    logic [DIV_WW-1:0] shd;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign quo_in = '0;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_comb begin
      shd     = DIV_WW'(den_in) << (DIV_QW - 1 - s);
      ge      = DIV_WW'(rem_in) >= shd;
      rem_nxt = ge ? DIV_NW'(DIV_WW'(rem_in) - shd) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[DIV_QW-1-s] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
      if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign out_valid = vld_r[DIV_QW-1];
  assign out_quo   = quo_r[DIV_QW-1];

endmodule

>>> hdl/fuzzy_pd_servo_gain.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_servo_gain
// Fuzzy PD gain: membership of error and rate, 7x7 rule table, weighted mean.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_ch    sink       error_value, error_rate (signed Q7.8)
//  out_ch   source     drive_value, no_rule_fired
//  cfg_*    write      output_step and six breakpoints, no read-back
//
// One request enters per cycle while the output is not stalled; its result
// passes the membership stage, five rule and sum stages and two 11-stage
// divider pipelines in series.
// Reset clears the valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module fuzzy_pd_servo_gain (
  input  logic                             clk,
  input  logic                             rst_n,
  fpsg_in_if.sink                          in_ch,
  fpsg_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fpsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpsg_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import fpsg_pkg::*;

  logic [7:0]       step_r;
  logic [BRK_W-1:0] eb1_r, eb2_r, eb3_r, rb1_r, rb2_r, rb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 8'd10;
      eb1_r <= 7'd20; eb2_r <= 7'd40; eb3_r <= 7'd60;
      rb1_r <= 7'd7;  rb2_r <= 7'd15; rb3_r <= 7'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_STEP: step_r <= cfg_data;
        REG_ERR_BREAK1:  eb1_r <= cfg_data[BRK_W-1:0];
        REG_ERR_BREAK2:  eb2_r <= cfg_data[BRK_W-1:0];
        REG_ERR_BREAK3:  eb3_r <= cfg_data[BRK_W-1:0];
        REG_RATE_BREAK1: rb1_r <= cfg_data[BRK_W-1:0];
        REG_RATE_BREAK2: rb2_r <= cfg_data[BRK_W-1:0];
        REG_RATE_BREAK3: rb3_r <= cfg_data[BRK_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Membership stage.
  mem_t me_r, mr_r;
  logic v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
    if (en) begin
      me_r <= member_sel(in_ch.error_value, eb1_r, eb2_r, eb3_r);
      mr_r <= member_sel(in_ch.error_rate, rb1_r, rb2_r, rb3_r);
    end
  end

  logic              dve, dvr;
  logic [DIV_QW-1:0] qe, qr;
  fpsg_div u_div_err (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1_r),
    .in_num(DIV_NW'(me_r.num) * DIV_NW'(100)), .in_den(me_r.den),
    .out_valid(dve), .out_quo(qe)
  );
  fpsg_div u_div_rate (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v1_r),
    .in_num(DIV_NW'(mr_r.num) * DIV_NW'(100)), .in_den(mr_r.den),
    .out_valid(dvr), .out_quo(qr)
  );

  side_t se_r [DIV_QW];
  side_t sr_r [DIV_QW];
  always_ff @(posedge clk) begin
    if (en) begin
      se_r[0] <= '{seg: me_r.seg, frc: me_r.frc, fw: me_r.fw};
      sr_r[0] <= '{seg: mr_r.seg, frc: mr_r.frc, fw: mr_r.fw};
      for (int i = 1; i < DIV_QW; i++) begin
        se_r[i] <= se_r[i-1];
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  // Rule lookup and strengths.
  side_t             de, dr;
  logic [WGT_W-1:0]  p0, p1, d0, d1;
  logic [LVL_W-1:0]  lvl_nxt [4];
  logic [WGT_W-1:0]  str_nxt [4];
  always_comb begin
    de = se_r[DIV_QW-1];
    dr = sr_r[DIV_QW-1];
    p0 = de.frc ? de.fw : qe[WGT_W-1:0];
    d0 = dr.frc ? dr.fw : qr[WGT_W-1:0];
    p1 = FULL_WEIGHT - p0;
    d1 = FULL_WEIGHT - d0;
    lvl_nxt[0] = RULE_TAB[de.seg - 3'd1][dr.seg - 3'd1];
    lvl_nxt[1] = RULE_TAB[de.seg][dr.seg - 3'd1];
    lvl_nxt[2] = RULE_TAB[de.seg - 3'd1][dr.seg];
    lvl_nxt[3] = RULE_TAB[de.seg][dr.seg];
    str_nxt[0] = (p0 <= d0) ? p0 : d0;
    str_nxt[1] = (p1 <= d0) ? p1 : d0;
    str_nxt[2] = (p0 <= d1) ? p0 : d1;
    str_nxt[3] = (p1 <= d1) ? p1 : d1;
  end

  logic [LVL_W-1:0] lvl2_r [4];
  logic [WGT_W-1:0] str2_r [4];
  logic             v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= dve && dvr;
    if (en) begin
      lvl2_r <= lvl_nxt;
      str2_r <= str_nxt;
    end
  end

  // Only the strongest rule of each output level survives.
  logic [WGT_W-1:0] ded [4];
  always_comb begin
    ded = str2_r;
    for (int a = 0; a < 3; a++) begin
      for (int b = a + 1; b < 4; b++) begin
        if (lvl2_r[a] == lvl2_r[b]) begin
          if (ded[a] > ded[b]) ded[b] = '0;
          else ded[a] = '0;
        end
      end
    end
  end

  logic [LVL_W-1:0] lvl3_r [4];
  logic [WGT_W-1:0] str3_r [4];
  logic             v3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      lvl3_r <= lvl2_r;
      str3_r <= ded;
    end
  end

  logic [9:0] t1_r [4];
  logic [8:0] den4_r, den5_r, den6_r;
  logic       v4_r, v5_r, v6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        t1_r[k] <= 10'(str3_r[k] * (4'(lvl3_r[k]) + 4'd2));
      end
      den4_r <= 9'(str3_r[0]) + 9'(str3_r[1]) + 9'(str3_r[2]) + 9'(str3_r[3]);
    end
  end

  logic [17:0] t2_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        t2_r[k] <= 18'(t1_r[k] * step_r);
      end
      den5_r <= den4_r;
    end
  end

  logic [19:0] num6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
    if (en) begin
      num6_r <= 20'(t2_r[0]) + 20'(t2_r[1]) + 20'(t2_r[2]) + 20'(t2_r[3]);
      den6_r <= den5_r;
    end
  end

  logic              vq;
  logic [DIV_QW-1:0] qf;
  fpsg_div u_div_out (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v6_r),
    .in_num(DIV_NW'(num6_r)), .in_den(DIV_DW'(den6_r)),
    .out_valid(vq), .out_quo(qf)
  );

  logic [DIV_QW-1:0] zd_r;
  always_ff @(posedge clk) begin
    if (en) zd_r <= {zd_r[DIV_QW-2:0], den6_r == 9'd0};
  end

  assign out_ch.valid         = vq;
  assign out_ch.no_rule_fired = zd_r[DIV_QW-1];
  assign out_ch.drive_value   = zd_r[DIV_QW-1] ? '0 : DRIVE_W'(qf);

endmodule

>>> hdl/fpsg_checker.sv
// ----------------------------------------------------------------------------
// fpsg_checker
// Port-level checks of the fuzzy PD servo gain block, bound to the top level.
// ----------------------------------------------------------------------------
module fpsg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] drive_value,
  input logic        no_rule_fired
);

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_rule_fired |-> drive_value == 11'd0)
    else $error("flagged result carries a drive value");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> drive_value <= 11'd2040)
    else $error("drive value above the top output level");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive_value))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind fuzzy_pd_servo_gain fpsg_checker u_fpsg_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .drive_value(out_ch.drive_value), .no_rule_fired(out_ch.no_rule_fired)
);
